@@ rtl/core/bfrf_pkg.sv @@
// Package for the blended ellipse ring fill block.
// Holds screen limits, register indexes, shared types and helper functions.
// Depends on nothing.
package bfrf_pkg;

  localparam int SCREEN_WIDTH  = 1024;
  localparam int SCREEN_HEIGHT = 1024;

  typedef enum logic [2:0] {
    REG_OUTER_CENTER  = 3'd0,
    REG_OUTER_RADII   = 3'd1,
    REG_INNER_CENTER  = 3'd2,
    REG_INNER_RADII   = 3'd3,
    REG_FILL_COLOR    = 3'd4,
    REG_BLEND_PERCENT = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [14:0] rx;
    logic [14:0] ry;
  } span_radii_t;

  // Absolute distance between an unsigned screen coordinate and a signed center.
  function automatic logic [15:0] abs_dist(input logic [9:0] pos, input logic [15:0] c);
    logic [16:0] d;
    logic [16:0] nd;
    d  = {7'b0, pos} - {c[15], c};
    nd = 17'd0 - d;
    return d[16] ? nd[15:0] : d[15:0];
  endfunction

  function automatic logic radius_ok(input logic [15:0] r);
    return !r[15] && (r != 16'd0);
  endfunction

endpackage

@@ rtl/core/bfrf_span.sv @@
// Row span test of one ellipse, three register stages deep.
// Compares n = 4*rx^2*(ry^2-dy^2) with (ry*(2*dx-1))^2 instead of a root and a divide.
// Depends on bfrf_pkg.
module bfrf_span (
  input  logic                 clk_i,
  input  logic [15:0]          adx_i,
  input  logic [15:0]          ady_i,
  input  bfrf_pkg::span_radii_t radii_i,
  output logic                 inside_o
);
  import bfrf_pkg::*;

  logic        inrow2_q, dzero2_q;
  logic [29:0] dy2_q, ry2_q, rx2_a_q;
  logic [32:0] t_q;
  logic        inrow3_q, dzero3_q, big3_q;
  logic [29:0] m_q, rx2_b_q;
  logic [61:0] tsq3_q;
  logic        inrow4_q, dzero4_q, big4_q;
  logic [61:0] tsq4_q, n_q;
  logic [16:0] odd_d;
  logic [59:0] prod_d;

  assign odd_d  = {1'b0, adx_i} + {1'b0, adx_i} - 17'd1;
  assign prod_d = rx2_b_q * m_q;

  always_ff @(posedge clk_i) begin
    inrow2_q <= ady_i <= {1'b0, radii_i.ry};
    dzero2_q <= adx_i == 16'd0;
    dy2_q    <= 30'(ady_i * ady_i);
    ry2_q    <= radii_i.ry * radii_i.ry;
    rx2_a_q  <= radii_i.rx * radii_i.rx;
    t_q      <= 33'(radii_i.ry * odd_d);

    inrow3_q <= inrow2_q;
    dzero3_q <= dzero2_q;
    big3_q   <= |t_q[32:31];
    m_q      <= ry2_q - dy2_q;
    rx2_b_q  <= rx2_a_q;
    tsq3_q   <= t_q[30:0] * t_q[30:0];

    inrow4_q <= inrow3_q;
    dzero4_q <= dzero3_q;
    big4_q   <= big3_q;
    tsq4_q   <= tsq3_q;
    n_q      <= {prod_d, 2'b00};
  end

  assign inside_o = inrow4_q && (dzero4_q || (!big4_q && (n_q >= tsq4_q)));

endmodule

@@ rtl/core/bfrf_blend.sv @@
// Per-byte alpha blend of the source pixel with the fill color, three stages deep.
// Also delays the source pixel by the same amount. Depends on bfrf_pkg.
module bfrf_blend (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] pixel_i,
  input  logic [23:0] color_i,
  input  logic [6:0]  percent_i,
  output logic [31:0] blend_o,
  output logic [31:0] pixel_o
);
  import bfrf_pkg::*;

  logic [6:0]  p_d;
  logic [19:0] ma_d, mb_d;
  logic [8:0]  a_q, b_q;
  logic [31:0] color32_d;
  logic [16:0] sum2_q [4];
  logic [16:0] sum3_q [4];
  logic [16:0] sum4_q [4];
  logic [31:0] src2_q, src3_q, src4_q;

  assign p_d       = (percent_i > 7'd100) ? 7'd100 : percent_i;
  assign ma_d      = p_d * 20'd5243;
  assign mb_d      = (7'd100 - p_d) * 20'd5243;
  assign color32_d = {8'h00, color_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= 9'd256;
      b_q <= 9'd0;
    end else begin
      a_q <= ma_d[19:11];
      b_q <= mb_d[19:11];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      sum2_q[k] <= 17'(pixel_i[8*k +: 8] * b_q) + 17'(color32_d[8*k +: 8] * a_q);
      sum3_q[k] <= sum2_q[k];
      sum4_q[k] <= sum3_q[k];
    end
    src2_q <= pixel_i;
    src3_q <= src2_q;
    src4_q <= src3_q;
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      blend_o[8*k +: 8] = sum4_q[k][16] ? 8'hff : sum4_q[k][15:8];
    end
  end

  assign pixel_o = src4_q;

endmodule

@@ rtl/core/blended_ellipse_ring_fill.sv @@
// Top level of the blended ellipse ring fill block.
// Depends on bfrf_pkg, bfrf_span and bfrf_blend.
//
// The block takes one pixel in every clock cycle and gives one registered result per
// cycle through the span stages, flagged by result_valid_o for one cycle. busy is
// always low, since the receiver cannot stall and the pipeline never holds an item.
// The depth is set by the span test: two squarings, a 30 by 30 product and a 62-bit
// compare, each behind its own register.
module blended_ellipse_ring_fill (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic [9:0]  pos_x_i,
  input  logic [9:0]  pos_y_i,
  input  logic [31:0] pixel_in_i,
  output logic [31:0] pixel_out_o,
  output logic        painted_o,
  output logic        result_valid_o
);
  import bfrf_pkg::*;

  logic [31:0] outer_center_q, outer_radii_q, inner_center_q, inner_radii_q;
  logic [23:0] fill_color_q;
  logic [6:0]  blend_percent_q;

  logic [3:0]  valid_q;
  logic        ok_q [4];
  logic [15:0] adx_o_q, ady_o_q, adx_i_q, ady_i_q;
  logic [31:0] src1_q;
  logic        ok_d;
  span_radii_t outer_r, inner_r;
  logic        in_outer, in_inner;
  logic [31:0] blend_px, src_px;
  logic [31:0] pixel_out_q;
  logic        painted_q, out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outer_center_q  <= '0;
      outer_radii_q   <= '0;
      inner_center_q  <= '0;
      inner_radii_q   <= '0;
      fill_color_q    <= '0;
      blend_percent_q <= 7'd100;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_OUTER_CENTER:  outer_center_q  <= cfg_wdata_i;
        REG_OUTER_RADII:   outer_radii_q   <= cfg_wdata_i;
        REG_INNER_CENTER:  inner_center_q  <= cfg_wdata_i;
        REG_INNER_RADII:   inner_radii_q   <= cfg_wdata_i;
        REG_FILL_COLOR:    fill_color_q    <= cfg_wdata_i[23:0];
        REG_BLEND_PERCENT: blend_percent_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  assign ok_d = radius_ok(outer_radii_q[15:0]) && radius_ok(outer_radii_q[31:16]) &&
                radius_ok(inner_radii_q[15:0]) && radius_ok(inner_radii_q[31:16]) &&
                ({22'b0, pos_x_i} < 32'(SCREEN_WIDTH)) &&
                ({22'b0, pos_y_i} < 32'(SCREEN_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= {valid_q[2:0], start};
      out_valid_q <= valid_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q[0] <= ok_d;
    for (int k = 1; k < 4; k++) begin
      ok_q[k] <= ok_q[k-1];
    end
    adx_o_q <= abs_dist(pos_x_i, outer_center_q[15:0]);
    ady_o_q <= abs_dist(pos_y_i, outer_center_q[31:16]);
    adx_i_q <= abs_dist(pos_x_i, inner_center_q[15:0]);
    ady_i_q <= abs_dist(pos_y_i, inner_center_q[31:16]);
    src1_q  <= pixel_in_i;
    painted_q   <= ok_q[3] && in_outer && !in_inner;
    pixel_out_q <= (ok_q[3] && in_outer && !in_inner) ? blend_px : src_px;
  end

  assign outer_r.rx = outer_radii_q[14:0];
  assign outer_r.ry = outer_radii_q[30:16];
  assign inner_r.rx = inner_radii_q[14:0];
  assign inner_r.ry = inner_radii_q[30:16];

  bfrf_span u_outer (
    .clk_i    (clk_i),
    .adx_i    (adx_o_q),
    .ady_i    (ady_o_q),
    .radii_i  (outer_r),
    .inside_o (in_outer)
  );

  bfrf_span u_inner (
    .clk_i    (clk_i),
    .adx_i    (adx_i_q),
    .ady_i    (ady_i_q),
    .radii_i  (inner_r),
    .inside_o (in_inner)
  );

  bfrf_blend u_blend (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pixel_i   (src1_q),
    .color_i   (fill_color_q),
    .percent_i (blend_percent_q),
    .blend_o   (blend_px),
    .pixel_o   (src_px)
  );

  assign busy           = 1'b0;
  assign pixel_out_o    = pixel_out_q;
  assign painted_o      = painted_q;
  assign result_valid_o = out_valid_q;

endmodule
